@@ design/cqd_pkg.sv @@
`default_nettype none

package cqd_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_DUMP   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       insert_we;   // write value at tail, advance tail, count up
      logic       remove_adv;  // advance head, count down
      logic       walk_start;  // load walk pointer from head
      logic       walk_all;    // walk length is occupancy (dump), else one entry
      logic       ram_re;      // read storage at walk pointer
      logic       walk_step;   // advance walk pointer, count down
      logic       out_imm;     // load result register with zero data and imm_status
      logic       out_ram;     // load result register with storage read data
      status_type imm_status;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic walk_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ design/circular_queue_with_dump.sv @@
`default_nettype none

// Circular queue of DEPTH signed 32-bit values with insert, remove and dump.
// Each request transaction carries an operation in req_tuser and a value in
// req_tdata. Insert and remove give one response transaction each, with
// status overflow or underflow when the queue is full or empty (data zero).
// Dump gives one response per stored entry, oldest first, with rsp_tlast on
// the newest, or a single empty-status response when nothing is stored; it
// leaves the queue unchanged. Operation code 3 is dropped without a response.
// Insert, the unused code, a failed remove and an empty dump finish in the
// idle state; remove and dump pass through the read-issue and load states
// once per entry read. The storage is a single RAM with registered read, so
// each entry read needs a read-issue step and a load step into the response
// register. Response backpressure adds stall cycles. Storage needs no
// clearing after reset: only slots written by an insert are ever read.

module circular_queue_with_dump #(
   parameter int DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] op

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] data_out
   output logic      [1:0]  rsp_tuser,   // [1:0] status
   output logic             rsp_tlast
);

   cqd_pkg::cmd_type  cmd;
   cqd_pkg::stat_type stat;

   // controller: sequences one request transaction at a time
   cqd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: pointers, occupancy, storage RAM and response register
   cqd_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_value  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ design/cqd_ram.sv @@
`default_nettype none

module cqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/cqd_ctrl.sv @@
`default_nettype none

module cqd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic [1:0]        req_op,
   output logic                   req_tready,
   input  wire cqd_pkg::stat_type stat,
   output cqd_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && stat.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      cmd.imm_status = cqd_pkg::ST_OK;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cqd_pkg::op_type'(req_op))
                  cqd_pkg::OP_INSERT: begin
                     cmd.out_imm = 1'b1;
                     if (stat.full) begin
                        cmd.imm_status = cqd_pkg::ST_OVERFLOW;
                     end else begin
                        cmd.insert_we = 1'b1;
                     end
                  end
                  cqd_pkg::OP_REMOVE: begin
                     if (stat.empty) begin
                        cmd.out_imm    = 1'b1;
                        cmd.imm_status = cqd_pkg::ST_UNDERFLOW;
                     end else begin
                        cmd.remove_adv = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_in       = S_READ;
                     end
                  end
                  cqd_pkg::OP_DUMP: begin
                     if (stat.empty) begin
                        cmd.out_imm    = 1'b1;
                        cmd.imm_status = cqd_pkg::ST_EMPTY;
                     end else begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_all   = 1'b1;
                        state_in       = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.ram_re = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.out_ram = 1'b1;
               if (stat.walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk_step = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // storage data is only taken in the load state, after a read was issued
   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ram |-> $past(state_ff == S_READ) || $past(state_ff == S_LOAD))
      else $error("result loaded from storage without a preceding read");

endmodule

`default_nettype wire

@@ design/cqd_dpath.sv @@
`default_nettype none

module cqd_dpath #(
   parameter int DEPTH = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cqd_pkg::cmd_type            cmd,
   output cqd_pkg::stat_type                stat,
   input  wire logic [cqd_pkg::DATA_W-1:0]  req_value,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [cqd_pkg::DATA_W-1:0]  rsp_data,
   output logic      [1:0]                  rsp_status,
   output logic                             rsp_last
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [PTR_W-1:0] walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cqd_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [cqd_pkg::DATA_W-1:0] ram_rd_data;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
      next_slot = (idx == PTR_MAX) ? '0 : idx + PTR_W'(1);
   endfunction

   cqd_ram #(
      .WIDTH (cqd_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.insert_we),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_en   (cmd.ram_re),
      .rd_addr (walk_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign stat.full      = (occ_ff == CNT_FULL);
   assign stat.empty     = (occ_ff == '0);
   assign stat.walk_last = (walk_cnt_ff == CNT_ONE);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      walk_idx_in = walk_idx_ff;
      walk_cnt_in = walk_cnt_ff;
      if (cmd.insert_we) begin
         tail_in = next_slot(tail_ff);
         occ_in  = occ_ff + CNT_ONE;
      end
      if (cmd.remove_adv) begin
         head_in = next_slot(head_ff);
         occ_in  = occ_ff - CNT_ONE;
      end
      if (cmd.walk_start) begin
         walk_idx_in = head_ff;
         walk_cnt_in = cmd.walk_all ? occ_ff : CNT_ONE;
      end else if (cmd.walk_step) begin
         walk_idx_in = next_slot(walk_idx_ff);
         walk_cnt_in = walk_cnt_ff - CNT_ONE;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.out_imm) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = cmd.imm_status;
         rsp_last_in   = 1'b1;
      end else if (cmd.out_ram) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = ram_rd_data;
         rsp_status_in = cqd_pkg::ST_OK;
         rsp_last_in   = stat.walk_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff   <= walk_idx_in;
      walk_cnt_ff   <= walk_cnt_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // tail must sit occupancy slots past head, modulo depth
   logic [CNT_W:0]   ptr_sum;
   logic [PTR_W-1:0] tail_expect;

   assign ptr_sum     = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(occ_ff);
   assign tail_expect = (ptr_sum >= (CNT_W + 1)'(DEPTH)) ?
                        PTR_W'(ptr_sum - (CNT_W + 1)'(DEPTH)) : PTR_W'(ptr_sum);

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_FULL)
      else $error("occupancy beyond depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_expect == tail_ff)
      else $error("head, tail and occupancy disagree");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_imm || cmd.out_ram) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire
